FILE: design/box_mean_filter_rgb_core_assert.svh
// Assertion macros for the box mean filter RTL.
`ifndef BOX_MEAN_FILTER_RGB_CORE_ASSERT_SVH
`define BOX_MEAN_FILTER_RGB_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BMF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BMF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BMF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BMF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: design/bmf_pkg.sv
// Shared types and constants of the box mean filter.
`timescale 1ns / 1ps
package bmf_pkg;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 11;
   localparam int PIX_W  = 8;
   localparam int MEAN_W = 16;

   localparam logic [CSR_IW-1:0] REG_WINDOW = 2'd0;
   localparam logic [CSR_IW-1:0] REG_WIDTH  = 2'd1;
   localparam logic [CSR_IW-1:0] REG_HEIGHT = 2'd2;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   localparam logic [CSR_DW-1:0] WINDOW_RST = 11'd3;
   localparam logic [CSR_DW-1:0] WIDTH_RST  = 11'd640;
   localparam logic [CSR_DW-1:0] HEIGHT_RST = 11'd480;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SUM, ST_FLUSH, ST_DIV, ST_DONE
   } back_state_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic idle;
   } back_status_type;
endpackage

FILE: design/bmf_queue.sv
// Two-entry job queue between the front and the back.
`timescale 1ns / 1ps
module bmf_queue #(
   parameter int DATA_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DATA_W-1:0]          push_data,
   input  logic                       pop,
   output logic [DATA_W-1:0]          pop_data,
   output bmf_pkg::queue_status_type  status
);
   import bmf_pkg::*;

   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      status.empty = (cnt_ff == 2'd0);
      status.full  = (cnt_ff == 2'd2);
      pop_data = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

FILE: design/bmf_front.sv
// Front end: registers, pixel counters, line store writes and job issue.
`timescale 1ns / 1ps
module bmf_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_WINDOW = 31,
   parameter int XW = $clog2(MAX_WIDTH),
   parameter int RW = $clog2(MAX_WINDOW + 1),
   parameter int WW = $clog2(MAX_WINDOW + 1),
   parameter int JOB_W = RW + WW + 2 * XW + 2 * WW + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [bmf_pkg::CSR_IW-1:0]    csr_index,
   input  logic [bmf_pkg::CSR_DW-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [bmf_pkg::PIX_W-1:0]     req_red_in,
   input  logic [bmf_pkg::PIX_W-1:0]     req_green_in,
   input  logic [bmf_pkg::PIX_W-1:0]     req_blue_in,
   input  bmf_pkg::queue_status_type     q_status,
   input  bmf_pkg::back_status_type      back_status,
   output logic                          wr_en,
   output logic [RW-1:0]                 wr_ring,
   output logic [XW-1:0]                 wr_col,
   output logic [3*bmf_pkg::PIX_W-1:0]   wr_data,
   output logic                          job_push,
   output logic [JOB_W-1:0]              job_data
);
   import bmf_pkg::*;

   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int RING = MAX_WINDOW + 1;
   localparam int CAPW = (MAX_WINDOW - 1) | 1;

   logic [CSR_DW-1:0] win_reg_ff, fw_reg_ff, fh_reg_ff;
   logic [XW-1:0]     in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [YW-1:0]     in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [RW-1:0]     in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   logic              in_done_ff, in_done_in;

   logic [XW-1:0]     fwm1;
   logic [YW-1:0]     fhm1;
   logic [4:0]        win_odd;
   logic [WW-1:0]     win, half;
   logic [2*WW-1:0]   div;
   logic              accept, is_px, emit, last;
   logic [YW:0]       need_r_raw, need_r, r0;
   logic [XW:0]       need_c_raw, need_c, c0;
   logic [RW-1:0]     ring0;
   logic [WW-1:0]     nrows;

   always_comb begin
      if (fw_reg_ff == '0) begin
         fwm1 = '0;
      end else if (32'(fw_reg_ff) > MAX_WIDTH) begin
         fwm1 = XW'(MAX_WIDTH - 1);
      end else begin
         fwm1 = XW'(fw_reg_ff - 1'b1);
      end
      if (fh_reg_ff == '0) begin
         fhm1 = '0;
      end else if (32'(fh_reg_ff) > MAX_HEIGHT) begin
         fhm1 = YW'(MAX_HEIGHT - 1);
      end else begin
         fhm1 = YW'(fh_reg_ff - 1'b1);
      end
      win_odd = win_reg_ff[4:0] | 5'd1;
      win = (32'(win_odd) > MAX_WINDOW) ? WW'(CAPW) : WW'(win_odd);
      half = win >> 1;
      div = (2*WW)'(win) * (2*WW)'(win);

      req_ready = !q_status.full && (in_done_ff || (q_status.empty && back_status.idle));
      accept = req_valid && req_ready;
      is_px = accept && (req_kind == KIND_PIXEL) && !in_done_ff;

      // store the pixel first, then decide on the pending result
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      in_ring_in = in_ring_ff;
      in_done_in = in_done_ff;
      if (is_px) begin
         if (in_col_ff == fwm1) begin
            in_col_in = '0;
            if (in_row_ff == fhm1) begin
               in_done_in = 1'b1;
            end else begin
               in_row_in = in_row_ff + 1'b1;
               in_ring_in = (in_ring_ff == RW'(RING - 1)) ? '0 : in_ring_ff + 1'b1;
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end

      need_r_raw = {1'b0, out_row_ff} + (YW+1)'(half);
      need_r = (need_r_raw > {1'b0, fhm1}) ? {1'b0, fhm1} : need_r_raw;
      need_c_raw = {1'b0, out_col_ff} + (XW+1)'(half);
      need_c = (need_c_raw > {1'b0, fwm1}) ? {1'b0, fwm1} : need_c_raw;
      emit = accept && (in_done_in || ({1'b0, in_row_in} > need_r)
             || (({1'b0, in_row_in} == need_r) && ({1'b0, in_col_in} > need_c)));
      last = (out_row_ff == fhm1) && (out_col_ff == fwm1);

      if (out_row_ff >= YW'(half)) begin
         r0 = {1'b0, out_row_ff - YW'(half)};
         ring0 = (out_ring_ff >= RW'(half)) ? out_ring_ff - RW'(half)
                 : RW'(out_ring_ff + RW'(RING) - RW'(half));
      end else begin
         r0 = '0;
         ring0 = '0;
      end
      c0 = (out_col_ff >= XW'(half)) ? {1'b0, out_col_ff - XW'(half)} : '0;
      nrows = WW'(need_r - r0);

      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      out_ring_in = out_ring_ff;
      if (emit) begin
         if (last) begin
            in_col_in = '0;
            in_row_in = '0;
            in_ring_in = '0;
            in_done_in = 1'b0;
            out_col_in = '0;
            out_row_in = '0;
            out_ring_in = '0;
         end else if (out_col_ff == fwm1) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
            out_ring_in = (out_ring_ff == RW'(RING - 1)) ? '0 : out_ring_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end

      wr_en = is_px;
      wr_ring = in_ring_ff;
      wr_col = in_col_ff;
      wr_data = {req_blue_in, req_green_in, req_red_in};
      job_push = emit;
      job_data = {ring0, nrows, XW'(c0), XW'(need_c), div, last};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_reg_ff <= WINDOW_RST;
         fw_reg_ff <= WIDTH_RST;
         fh_reg_ff <= HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_WINDOW: win_reg_ff <= csr_wdata;
            REG_WIDTH:  fw_reg_ff <= csr_wdata;
            REG_HEIGHT: fh_reg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (csr_wr_en
                    && (csr_index inside {REG_WINDOW, REG_WIDTH, REG_HEIGHT}))) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
         in_ring_ff <= '0;
         in_done_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         out_ring_ff <= '0;
      end else begin
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         in_ring_ff <= in_ring_in;
         in_done_ff <= in_done_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         out_ring_ff <= out_ring_in;
      end
   end
endmodule

FILE: design/bmf_back.sv
// Back end: line store, window summing sequencer, divider and result register.
`timescale 1ns / 1ps
`include "box_mean_filter_rgb_core_assert.svh"
module bmf_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_WINDOW = 31,
   parameter int XW = $clog2(MAX_WIDTH),
   parameter int RW = $clog2(MAX_WINDOW + 1),
   parameter int WW = $clog2(MAX_WINDOW + 1),
   parameter int JOB_W = RW + WW + 2 * XW + 2 * WW + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [RW-1:0]                 wr_ring,
   input  logic [XW-1:0]                 wr_col,
   input  logic [3*bmf_pkg::PIX_W-1:0]   wr_data,
   input  bmf_pkg::queue_status_type     q_status,
   input  logic [JOB_W-1:0]              job_data,
   output logic                          job_pop,
   output bmf_pkg::back_status_type      back_status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bmf_pkg::MEAN_W-1:0]    rsp_red_mean,
   output logic [bmf_pkg::MEAN_W-1:0]    rsp_green_mean,
   output logic [bmf_pkg::MEAN_W-1:0]    rsp_blue_mean,
   output logic                          rsp_frame_end
);
   import bmf_pkg::*;

   localparam int RING = MAX_WINDOW + 1;
   localparam int SW   = $clog2(255 * MAX_WINDOW * MAX_WINDOW + 1);
   localparam int QW   = SW + 8;
   localparam int DW   = 2 * WW;
   localparam int KW   = $clog2(QW + 1);

   logic [3*PIX_W-1:0] mem [RING][MAX_WIDTH];

   back_state_type st_ff, st_in;
   logic [RW-1:0]  ring_ff, ring_in;
   logic [WW-1:0]  rcnt_ff, rcnt_in;
   logic [XW-1:0]  col_ff, col_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [DW-1:0]  div_ff, div_in;
   logic           last_ff, last_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [3*PIX_W-1:0] rd_data_ff;
   logic [SW-1:0]  acc_ff [3];
   logic [SW-1:0]  acc_in [3];
   logic [QW-1:0]  dvd_ff [3];
   logic [QW-1:0]  dvd_in [3];
   logic [QW-1:0]  quo_ff [3];
   logic [QW-1:0]  quo_in [3];
   logic [DW-1:0]  rem_ff [3];
   logic [DW-1:0]  rem_in [3];
   logic [DW:0]    rem_t  [3];
   logic [KW-1:0]  step_ff, step_in;
   logic           out_vld_ff, out_vld_in, out_load;
   logic [MEAN_W-1:0] mean_ff [3];
   logic           fe_ff;

   // job layout: ring0, rows-1, first col, last col, divisor, last flag
   logic [RW-1:0]  j_ring;
   logic [WW-1:0]  j_rows;
   logic [XW-1:0]  j_c0, j_c1;
   logic [DW-1:0]  j_div;
   logic           j_last;

   always_comb begin
      {j_ring, j_rows, j_c0, j_c1, j_div, j_last} = job_data;
      st_in = st_ff;
      ring_in = ring_ff;
      rcnt_in = rcnt_ff;
      col_in = col_ff;
      c0_in = c0_ff;
      c1_in = c1_ff;
      div_in = div_ff;
      last_in = last_ff;
      rd_vld_in = 1'b0;
      step_in = step_ff;
      job_pop = 1'b0;
      out_load = 1'b0;
      back_status.idle = (st_ff == ST_IDLE);
      for (int k = 0; k < 3; k++) begin
         acc_in[k] = rd_vld_ff ? acc_ff[k] + SW'(rd_data_ff[k*PIX_W +: PIX_W]) : acc_ff[k];
         dvd_in[k] = dvd_ff[k];
         quo_in[k] = quo_ff[k];
         rem_in[k] = rem_ff[k];
         rem_t[k] = {rem_ff[k], dvd_ff[k][QW-1]};
      end
      case (st_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               job_pop = 1'b1;
               ring_in = j_ring;
               rcnt_in = j_rows;
               col_in = j_c0;
               c0_in = j_c0;
               c1_in = j_c1;
               div_in = j_div;
               last_in = j_last;
               for (int k = 0; k < 3; k++) acc_in[k] = '0;
               st_in = ST_SUM;
            end
         end
         ST_SUM: begin
            rd_vld_in = 1'b1;
            if (col_ff == c1_ff) begin
               col_in = c0_ff;
               if (rcnt_ff == '0) begin
                  st_in = ST_FLUSH;
               end else begin
                  rcnt_in = rcnt_ff - 1'b1;
                  ring_in = (ring_ff == RW'(RING - 1)) ? '0 : ring_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            // last read word lands this cycle
            for (int k = 0; k < 3; k++) begin
               dvd_in[k] = {acc_in[k], 8'd0};
               quo_in[k] = '0;
               rem_in[k] = '0;
            end
            step_in = '0;
            st_in = ST_DIV;
         end
         ST_DIV: begin
            for (int k = 0; k < 3; k++) begin
               dvd_in[k] = dvd_ff[k] << 1;
               if (rem_t[k] >= {1'b0, div_ff}) begin
                  rem_in[k] = DW'(rem_t[k] - {1'b0, div_ff});
                  quo_in[k] = {quo_ff[k][QW-2:0], 1'b1};
               end else begin
                  rem_in[k] = DW'(rem_t[k]);
                  quo_in[k] = {quo_ff[k][QW-2:0], 1'b0};
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == KW'(QW - 1)) begin
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_vld_ff || rsp_ready) begin
               out_load = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      out_vld_in = out_load || (out_vld_ff && !rsp_ready);
      rsp_valid = out_vld_ff;
      rsp_red_mean = mean_ff[0];
      rsp_green_mean = mean_ff[1];
      rsp_blue_mean = mean_ff[2];
      rsp_frame_end = fe_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ring][wr_col] <= wr_data;
      end
      rd_data_ff <= mem[ring_ff][col_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rd_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rd_vld_ff <= rd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ring_ff <= ring_in;
      rcnt_ff <= rcnt_in;
      col_ff <= col_in;
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      div_ff <= div_in;
      last_ff <= last_in;
      step_ff <= step_in;
      for (int k = 0; k < 3; k++) begin
         acc_ff[k] <= acc_in[k];
         dvd_ff[k] <= dvd_in[k];
         quo_ff[k] <= quo_in[k];
         rem_ff[k] <= rem_in[k];
         if (out_load) mean_ff[k] <= quo_ff[k][MEAN_W-1:0];
      end
      if (out_load) fe_ff <= last_ff;
   end

   // the line store must never be written while a window is being read
   `BMF_ASSERT_IMP(a_wr_only_idle, clock, reset, wr_en, st_ff == ST_IDLE)
   `BMF_ASSERT_NXT(a_flush_to_div, clock, reset, st_ff == ST_FLUSH, st_ff == ST_DIV)
   `BMF_ASSERT_NXT(a_pop_starts_sum, clock, reset, job_pop, st_ff == ST_SUM)
endmodule

FILE: design/box_mean_filter_rgb_core.sv
// Top level of the RGB box mean filter.
//  channel  direction  handshake              word
//  req      in         req_valid/req_ready    kind, red/green/blue sample
//  rsp      out        rsp_valid/rsp_ready    red/green/blue Q8.8 mean, frame_end
//  csr      in         csr_wr_en              csr_index, csr_wdata
// A word that completes a window is queued; the back end pops it, reads the window,
// flushes, runs 8 + sum-width divider steps and loads the result; window reads go
// one per cycle through the single line store read port. A word with no result is not
// queued. While a frame is arriving a pixel is taken only when the back end is idle;
// once it is in, result jobs are queued two deep. Reset clears the pixel counters; the
// line store is not cleared. A stalled rsp holds its word; one finished result may
// wait while the next is computed.
`timescale 1ns / 1ps
module box_mean_filter_rgb_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_WINDOW = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [bmf_pkg::CSR_IW-1:0]    csr_index,
   input  logic [bmf_pkg::CSR_DW-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [bmf_pkg::PIX_W-1:0]     req_red_in,
   input  logic [bmf_pkg::PIX_W-1:0]     req_green_in,
   input  logic [bmf_pkg::PIX_W-1:0]     req_blue_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bmf_pkg::MEAN_W-1:0]    rsp_red_mean,
   output logic [bmf_pkg::MEAN_W-1:0]    rsp_green_mean,
   output logic [bmf_pkg::MEAN_W-1:0]    rsp_blue_mean,
   output logic                          rsp_frame_end
);
   import bmf_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_WINDOW + 1);
   localparam int WW = $clog2(MAX_WINDOW + 1);
   localparam int JOB_W = RW + WW + 2 * XW + 2 * WW + 1;

   queue_status_type   q_status;
   back_status_type    back_status;
   logic               wr_en, job_push, job_pop;
   logic [RW-1:0]      wr_ring;
   logic [XW-1:0]      wr_col;
   logic [3*PIX_W-1:0] wr_data;
   logic [JOB_W-1:0]   push_job, pop_job;

   bmf_front #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WINDOW(MAX_WINDOW),
      .XW(XW), .RW(RW), .WW(WW), .JOB_W(JOB_W)
   ) u_front (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_red_in(req_red_in), .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .q_status(q_status), .back_status(back_status),
      .wr_en(wr_en), .wr_ring(wr_ring), .wr_col(wr_col), .wr_data(wr_data),
      .job_push(job_push), .job_data(push_job)
   );

   bmf_queue #(.DATA_W(JOB_W)) u_queue (
      .clock(clock), .reset(reset),
      .push(job_push), .push_data(push_job),
      .pop(job_pop), .pop_data(pop_job), .status(q_status)
   );

   bmf_back #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW),
      .XW(XW), .RW(RW), .WW(WW), .JOB_W(JOB_W)
   ) u_back (
      .clock(clock), .reset(reset),
      .wr_en(wr_en), .wr_ring(wr_ring), .wr_col(wr_col), .wr_data(wr_data),
      .q_status(q_status), .job_data(pop_job), .job_pop(job_pop),
      .back_status(back_status),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red_mean(rsp_red_mean), .rsp_green_mean(rsp_green_mean),
      .rsp_blue_mean(rsp_blue_mean), .rsp_frame_end(rsp_frame_end)
   );
endmodule

FILE: tb/tb.sv
// Self-checking testbench for the RGB box mean filter core.
`timescale 1ns / 1ps
module tb;
   import bmf_pkg::*;

   localparam int MAX_W   = 1024;
   localparam int MAX_H   = 1024;
   localparam int MAX_WIN = 31;
   localparam int RING    = MAX_WIN + 1;
   localparam logic [CSR_IW-1:0] REG_SPARE = 2'd3;
   localparam int SETTLE      = 1200;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 3000;
   localparam int RAND_ITEMS  = 600;

   typedef struct packed {
      logic [MEAN_W-1:0] red;
      logic [MEAN_W-1:0] green;
      logic [MEAN_W-1:0] blue;
      logic              fe;
   } mean_word_type;

   typedef struct {
      int         phase;
      logic       kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit         typed;
      bit         has_word;
      mean_word_type word;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = KIND_PIXEL;
   logic [PIX_W-1:0] req_red_in = '0;
   logic [PIX_W-1:0] req_green_in = '0;
   logic [PIX_W-1:0] req_blue_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [MEAN_W-1:0] rsp_red_mean;
   logic [MEAN_W-1:0] rsp_green_mean;
   logic [MEAN_W-1:0] rsp_blue_mean;
   logic rsp_frame_end;

   box_mean_filter_rgb_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_red_in(req_red_in), .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red_mean(rsp_red_mean), .rsp_green_mean(rsp_green_mean),
      .rsp_blue_mean(rsp_blue_mean), .rsp_frame_end(rsp_frame_end)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Filter state as seen from outside
   logic [23:0] line_mem [RING*MAX_W];
   int wnd_reg = 3, width_reg = 640, height_reg = 480;
   int in_col, in_row, out_col, out_row;
   bit in_done;

   mean_word_type mean_q[$];
   mean_word_type due_word;
   int errors;
   int words_sent;
   int idle_mode;
   int stall_cycles;
   int hold_left;
   bit start_hold;

   function automatic bit filter_step(input logic kind, input logic [7:0] r, g, b,
                                      output mean_word_type word);
      int fw, fh, win, half, need_r, need_c, r0, c0, rr, cc, div;
      int sr, sg, sb;
      logic [23:0] px;
      bit ready;
      bit last;
      fw = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
      fh = (height_reg == 0) ? 1 : ((height_reg > MAX_H) ? MAX_H : height_reg);
      win = wnd_reg | 1;
      if (win > MAX_WIN) win = (MAX_WIN - 1) | 1;
      half = win / 2;
      div = win * win;
      word = '0;
      if (kind == KIND_PIXEL && !in_done) begin
         line_mem[(in_row % RING) * MAX_W + in_col] = {b, g, r};
         in_col++;
         if (in_col >= fw) begin
            in_col = 0;
            in_row++;
            if (in_row >= fh) in_done = 1'b1;
         end
      end
      need_r = (out_row + half > fh - 1) ? fh - 1 : out_row + half;
      need_c = (out_col + half > fw - 1) ? fw - 1 : out_col + half;
      ready = in_done || in_row > need_r || (in_row == need_r && in_col > need_c);
      if (!ready) return 1'b0;
      r0 = (out_row >= half) ? out_row - half : 0;
      c0 = (out_col >= half) ? out_col - half : 0;
      sr = 0; sg = 0; sb = 0;
      for (rr = r0; rr <= need_r; rr++) begin
         for (cc = c0; cc <= need_c; cc++) begin
            px = line_mem[(rr % RING) * MAX_W + cc];
            sr += px[7:0];
            sg += px[15:8];
            sb += px[23:16];
         end
      end
      word.red   = 16'((sr * 256) / div);
      word.green = 16'((sg * 256) / div);
      word.blue  = 16'((sb * 256) / div);
      last = (out_row == fh - 1) && (out_col == fw - 1);
      word.fe = last;
      if (last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 1'b0;
      end else begin
         out_col++;
         if (out_col >= fw) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1'b1;
   endfunction

   task automatic write_csr(input logic [CSR_IW-1:0] idx, input int val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DW-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_WINDOW: wnd_reg = val & 31;
         REG_WIDTH:  width_reg = val & 2047;
         REG_HEIGHT: height_reg = val & 2047;
         default:    return;
      endcase
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; in_done = 1'b0;
   endtask

   // Offer one word; hold valid until taken
   task automatic offer(input stim_row_type row, output bit fe);
      mean_word_type word;
      bit got;
      int gap_pct;
      gap_pct = (idle_mode == 0) ? 24 : ((idle_mode == 1) ? 65 : 0);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      got = filter_step(row.kind, row.red, row.green, row.blue, word);
      if (row.typed) begin
         got = row.has_word;
         word = row.word;
      end
      if (got) mean_q.push_back(word);
      fe = got && word.fe;
      req_valid <= 1'b1;
      req_kind <= row.kind;
      req_red_in <= row.red;
      req_green_in <= row.green;
      req_blue_in <= row.blue;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      idle_mode = (words_sent < 630) ? 0 : ((words_sent < 1260) ? 1 : 2);
   endtask

   task automatic settle_phase();
      req_valid <= 1'b0;
      while (mean_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_window(input int wnd, input int w, input int h);
      settle_phase();
      write_csr(REG_WINDOW, wnd);
      write_csr(REG_WIDTH, w);
      write_csr(REG_HEIGHT, h);
   endtask

   function automatic logic [7:0] rand_sample();
      int pick;
      pick = $urandom_range(15);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   // Mostly pixels until the frame is in, then mostly drains until its last word
   task automatic run_frame();
      stim_row_type row;
      bit fe;
      fe = 1'b0;
      row.phase = 0;
      row.typed = 1'b0;
      row.has_word = 1'b0;
      row.word = '0;
      while (!fe) begin
         if (in_done) row.kind = ($urandom_range(99) < 85) ? KIND_DRAIN : KIND_PIXEL;
         else row.kind = ($urandom_range(99) < 8) ? KIND_DRAIN : KIND_PIXEL;
         row.red = rand_sample();
         row.green = rand_sample();
         row.blue = rand_sample();
         offer(row, fe);
      end
   endtask

   function automatic stim_row_type mk_row(input int phase, input logic kind,
                                           input logic [7:0] r, g, b, input bit typed,
                                           input bit has, input mean_word_type word);
      stim_row_type row;
      row.phase = phase;
      row.kind = kind;
      row.red = r;
      row.green = g;
      row.blue = b;
      row.typed = typed;
      row.has_word = has;
      row.word = word;
      return row;
   endfunction

   // Response side: check, throttle, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("box_mean_filter_rgb_core: mismatch");
            $finish;
         end else begin
            if (rsp_valid && rsp_ready) begin
               if (mean_q.size() == 0) begin
                  $error("unexpected word: red_mean %0h", rsp_red_mean);
                  errors++;
               end else begin
                  due_word = mean_q.pop_front();
                  if (rsp_red_mean !== due_word.red) begin
                     $error("red_mean: expected %0h, got %0h", due_word.red, rsp_red_mean);
                     errors++;
                  end
                  if (rsp_green_mean !== due_word.green) begin
                     $error("green_mean: expected %0h, got %0h", due_word.green,
                            rsp_green_mean);
                     errors++;
                  end
                  if (rsp_blue_mean !== due_word.blue) begin
                     $error("blue_mean: expected %0h, got %0h", due_word.blue,
                            rsp_blue_mean);
                     errors++;
                  end
                  if (rsp_frame_end !== due_word.fe) begin
                     $error("frame_end: expected %0b, got %0b", due_word.fe, rsp_frame_end);
                     errors++;
                  end
               end
            end
            if (start_hold) begin
               hold_left = HOLD_CYCLES;
               start_hold = 1'b0;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= ($urandom_range(99) >=
                             ((idle_mode == 0) ? 65 : ((idle_mode == 1) ? 24 : 0)));
            end
         end
      end
   end

   stim_row_type dir_rows[$];
   int setups [3][3] = '{'{3, 640, 480}, '{1, 2, 2}, '{3, 3, 2}};
   int extremes [10][3] = '{'{31, 5, 4}, '{0, 3, 3}, '{4, 4, 3}, '{30, 2, 2},
                            '{3, 2047, 1}, '{1, 0, 5}, '{3, 0, 0}, '{2, 1, 3},
                            '{7, 9, 1}, '{31, 1, 1}};

   initial begin
      int cur_phase, i, j, frames, rand_start, wnd, w, h;
      bit fe;
      mean_word_type none;
      none = '0;
      // Reset config: a few pixels, far from any complete window
      dir_rows.push_back(mk_row(0, KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 0, none));
      dir_rows.push_back(mk_row(0, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1, 0, none));
      dir_rows.push_back(mk_row(0, KIND_DRAIN, 8'h12, 8'h34, 8'h56, 1, 0, none));
      // Unit window on a 2x2 frame: each mean is the sample itself
      dir_rows.push_back(mk_row(1, KIND_DRAIN, 8'hAA, 8'h55, 8'hAA, 1, 0, none));
      dir_rows.push_back(mk_row(1, KIND_PIXEL, 8'hFF, 8'h00, 8'hFF, 1, 1,
                                '{16'hFF00, 16'h0000, 16'hFF00, 1'b0}));
      dir_rows.push_back(mk_row(1, KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 1, 1,
                                '{16'h0000, 16'hFF00, 16'h0000, 1'b0}));
      dir_rows.push_back(mk_row(1, KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1, 1,
                                '{16'hFF00, 16'hFF00, 16'hFF00, 1'b0}));
      dir_rows.push_back(mk_row(1, KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1, 1,
                                '{16'h0000, 16'h0000, 16'h0000, 1'b1}));
      // 3x3 window on 3x2: edge clipping, late pixel dropped, drains flush
      dir_rows.push_back(mk_row(2, KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 0, none));
      dir_rows.push_back(mk_row(2, KIND_PIXEL, 8'h01, 8'h80, 8'hFE, 0, 0, none));
      dir_rows.push_back(mk_row(2, KIND_PIXEL, 8'hFF, 8'h00, 8'h7F, 0, 0, none));
      dir_rows.push_back(mk_row(2, KIND_PIXEL, 8'h00, 8'hFF, 8'h00, 0, 0, none));
      dir_rows.push_back(mk_row(2, KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, 0, none));
      dir_rows.push_back(mk_row(2, KIND_PIXEL, 8'h55, 8'hAA, 8'h33, 0, 0, none));
      dir_rows.push_back(mk_row(2, KIND_PIXEL, 8'hEE, 8'hEE, 8'hEE, 0, 0, none));
      for (i = 0; i < 4; i++)
         dir_rows.push_back(mk_row(2, KIND_DRAIN, 8'h00, 8'h00, 8'h00, 0, 0, none));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_phase = 0;
      foreach (dir_rows[k]) begin
         if (dir_rows[k].phase != cur_phase) begin
            cur_phase = dir_rows[k].phase;
            set_window(setups[cur_phase][0], setups[cur_phase][1], setups[cur_phase][2]);
         end
         offer(dir_rows[k], fe);
      end

      settle_phase();
      write_csr(REG_SPARE, 5);
      for (i = 0; i < 10; i++) begin
         set_window(extremes[i][0], extremes[i][1], extremes[i][2]);
         // long downstream stall on the widest row: the core must back up
         if (i == 4) start_hold = 1'b1;
         run_frame();
         if (i == 0) run_frame();
      end

      rand_start = words_sent;
      while (words_sent - rand_start < RAND_ITEMS) begin
         if ($urandom_range(9) == 0) wnd = $urandom_range(31);
         else wnd = 2 * $urandom_range(3) + 1;
         w = (wnd > 9) ? $urandom_range(1, 4) : $urandom_range(1, 12);
         h = (wnd > 9) ? $urandom_range(1, 4) : $urandom_range(1, 8);
         set_window(wnd, w, h);
         frames = $urandom_range(1, 3);
         for (j = 0; j < frames; j++) run_frame();
      end

      settle_phase();
      if (errors == 0) begin
         $display("box_mean_filter_rgb_core: match");
      end else begin
         $display("box_mean_filter_rgb_core: mismatch");
      end
      $finish;
   end
endmodule
